[rtl/lifnds_pkg.sv]
// ----------------------------------------------------------------------------
// lifnds_pkg
// Shared sizes, codes and beat types of the LIF neuron with delay synapses.
// ----------------------------------------------------------------------------
package lifnds_pkg;

  localparam int N_SYNAPSES = 16;
  localparam int RING_DEPTH = 8;

  localparam int SYN_W  = (N_SYNAPSES > 1) ? $clog2(N_SYNAPSES) : 1;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = SYN_W + 1;
  // exact sum of up to N_SYNAPSES signed 16-bit weights
  localparam int SUM_W  = 16 + $clog2(N_SYNAPSES);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SPIKE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_POTENTIAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR     = 3'd4;

  localparam logic [15:0] THRESHOLD_RST       = 16'hCE00; // -50.0
  localparam logic [15:0] REST_POTENTIAL_RST  = 16'hBF00; // -65.0
  localparam logic [15:0] RESET_POTENTIAL_RST = 16'hBF00; // -65.0
  localparam logic [15:0] INPUT_GAIN_RST      = 16'd2560; // 10.0
  localparam logic [15:0] LEAK_FACTOR_RST     = 16'd6554; // about 0.1

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         syn_id;
    logic signed [15:0] weight;
    logic [7:0]         delay;
    logic [15:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic               spike;
    logic signed [15:0] membrane;
  } out_item_t;

  // one write-side command per cycle to the arrival ring
  typedef struct packed {
    logic              wr;    // store arrival, mark valid
    logic              clr;   // empty every slot of a synapse
    logic              kill;  // clear one consumed slot
    logic [SYN_W-1:0]  syn;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       arrival;
  } ring_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] arrival;
  } ring_rd_t;

endpackage

[rtl/lifnds_ring.sv]
// ----------------------------------------------------------------------------
// lifnds_ring
// Arrival-time ring store: synchronous memory plus per-slot valid flags.
// ----------------------------------------------------------------------------
module lifnds_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  lifnds_pkg::ring_cmd_t         cmd,
  input  logic                          rd_en,
  input  logic [lifnds_pkg::SYN_W-1:0]  rd_syn,
  input  logic [lifnds_pkg::SLOT_W-1:0] rd_slot,
  output lifnds_pkg::ring_rd_t          rd
);

  logic [15:0] mem [lifnds_pkg::N_SYNAPSES][lifnds_pkg::RING_DEPTH];
  logic        valid [lifnds_pkg::N_SYNAPSES][lifnds_pkg::RING_DEPTH];

  // times and read data, no reset: valid flags gate every read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.syn][cmd.slot] <= cmd.arrival;
    end
    if (rd_en) begin
      rd.arrival <= mem[rd_syn][rd_slot];
      rd.valid   <= valid[rd_syn][rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < lifnds_pkg::N_SYNAPSES; s++) begin
        for (int k = 0; k < lifnds_pkg::RING_DEPTH; k++) begin
          valid[s][k] <= 1'b0;
        end
      end
    end else begin
      if (cmd.wr) begin
        valid[cmd.syn][cmd.slot] <= 1'b1;
      end
      if (cmd.kill) begin
        valid[cmd.syn][cmd.slot] <= 1'b0;
      end
      if (cmd.clr) begin
        for (int k = 0; k < lifnds_pkg::RING_DEPTH; k++) begin
          valid[cmd.syn][k] <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/lif_neuron_with_delay_synapses_core.sv]
// ----------------------------------------------------------------------------
// lif_neuron_with_delay_synapses_core
// Leaky integrate-and-fire neuron with delayed input synapses, Q8.8 fixed point.
// ----------------------------------------------------------------------------
// One neuron fed by N_SYNAPSES synapses. A load beat sets a synapse's weight
// and delay and empties its arrival ring; a presynaptic spike beat queues
// time_step + delay in that synapse's ring. Both leave the core idle and give
// no result. A tick beat gives one result (spike flag and new membrane
// potential): after the accepting cycle the scan reads one ring head a cycle
// from the single-read-port arrival memory, then compares the last head, then
// the leak product, drive product and saturating update follow as steps of
// their own. The result sits in an output register, so load and spike beats
// are taken while it waits; a following tick holds in its last step until
// the output register is free, and no beat is taken before then. Register
// writes are applied at once, so a write during a tick can change that
// tick. No clearing pass after reset: ring slots carry valid flags.
// ----------------------------------------------------------------------------
module lif_neuron_with_delay_synapses_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lifnds_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lifnds_pkg::out_item_t               out_data,
  input  logic                                cfg_wr_en,
  input  logic [lifnds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int SYN_W  = lifnds_pkg::SYN_W;
  localparam int SLOT_W = lifnds_pkg::SLOT_W;
  localparam int CNT_W  = lifnds_pkg::CNT_W;
  localparam int SUM_W  = lifnds_pkg::SUM_W;
  localparam int LPROD_W = 34;          // 17-bit gain x 17-bit difference
  localparam int DPROD_W = 17 + SUM_W;  // 17-bit gain x summed weights
  localparam int TOT_W   = DPROD_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_LEAK   = 3'd2;
  localparam logic [2:0] ST_DRIVE  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  // configuration registers
  logic signed [15:0] threshold;
  logic signed [15:0] rest_potential;
  logic signed [15:0] reset_potential;
  logic [15:0]        input_gain;
  logic [15:0]        leak_factor;

  // per-synapse state in flops
  logic signed [15:0] syn_weight [lifnds_pkg::N_SYNAPSES];
  logic [7:0]         syn_delay  [lifnds_pkg::N_SYNAPSES];
  logic [SLOT_W-1:0]  ring_head  [lifnds_pkg::N_SYNAPSES];
  logic [SLOT_W-1:0]  ring_tail  [lifnds_pkg::N_SYNAPSES];

  logic signed [15:0] potential;
  logic [2:0]         state;
  logic [15:0]        now;
  logic [CNT_W-1:0]   issue_cnt;
  logic               cmp_act;
  logic [SYN_W-1:0]   cmp_syn;
  logic [SLOT_W-1:0]  cmp_slot;
  logic signed [SUM_W-1:0]   sum;
  logic signed [LPROD_W-1:0] leak_prod;
  logic signed [DPROD_W-1:0] drive_prod;

  logic                  accept;
  logic                  idx_ok;
  logic [SYN_W-1:0]      idx;
  logic [SYN_W-1:0]      issue_syn;
  logic                  issue_done;
  logic                  hit;
  logic                  out_free;
  lifnds_pkg::ring_cmd_t ring_cmd;
  lifnds_pkg::ring_rd_t  ring_rd;

  logic signed [LPROD_W-1:0] leak_rnd;
  logic signed [DPROD_W-1:0] drive_rnd;
  logic signed [TOT_W-1:0]   total;
  logic signed [15:0]        v_sat;
  logic                      fired;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(lifnds_pkg::RING_DEPTH - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_ok     = (32'(in_data.syn_id) < lifnds_pkg::N_SYNAPSES);
  assign idx        = SYN_W'(in_data.syn_id);
  assign issue_syn  = issue_cnt[SYN_W-1:0];
  assign issue_done = (issue_cnt == CNT_W'(lifnds_pkg::N_SYNAPSES));
  assign hit        = cmp_act && ring_rd.valid && (ring_rd.arrival == now);
  assign out_free   = !out_valid || out_ready;

  // ring write side: load empties, spike queues, scan consumes a matched head
  always_comb begin
    ring_cmd         = '0;
    ring_cmd.syn     = idx;
    ring_cmd.slot    = ring_tail[idx];
    ring_cmd.arrival = in_data.time_step + 16'(syn_delay[idx]);
    if (accept && idx_ok && in_data.op == lifnds_pkg::OP_LOAD) begin
      ring_cmd.clr = 1'b1;
    end
    if (accept && idx_ok && in_data.op == lifnds_pkg::OP_SPIKE) begin
      ring_cmd.wr = 1'b1;
    end
    if (state == ST_SCAN && hit) begin
      ring_cmd.kill = 1'b1;
      ring_cmd.syn  = cmp_syn;
      ring_cmd.slot = cmp_slot;
    end
  end

  lifnds_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .rd_en   (state == ST_SCAN && !issue_done),
    .rd_syn  (issue_syn),
    .rd_slot (ring_head[issue_syn]),
    .rd      (ring_rd)
  );

  // Scan reads synapse s while s-1 is compared and possibly consumed: the two
  // always touch different synapses, so no forwarding is needed.

  // membrane update: round half up, floor shift, saturate, fire
  always_comb begin
    leak_rnd  = leak_prod + LPROD_W'(32768);
    drive_rnd = drive_prod + DPROD_W'(128);
    total     = TOT_W'(potential) + TOT_W'(leak_rnd >>> 16) + TOT_W'(drive_rnd >>> 8);
    if (total > TOT_W'(32767)) begin
      v_sat = 16'sh7FFF;
    end else if (total < -TOT_W'(32768)) begin
      v_sat = -16'sh8000;
    end else begin
      v_sat = 16'(total);
    end
    fired = (v_sat >= threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= lifnds_pkg::THRESHOLD_RST;
      rest_potential  <= lifnds_pkg::REST_POTENTIAL_RST;
      reset_potential <= lifnds_pkg::RESET_POTENTIAL_RST;
      input_gain      <= lifnds_pkg::INPUT_GAIN_RST;
      leak_factor     <= lifnds_pkg::LEAK_FACTOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lifnds_pkg::REG_THRESHOLD:       threshold       <= cfg_data;
        lifnds_pkg::REG_REST_POTENTIAL:  rest_potential  <= cfg_data;
        lifnds_pkg::REG_RESET_POTENTIAL: reset_potential <= cfg_data;
        lifnds_pkg::REG_INPUT_GAIN:      input_gain      <= cfg_data;
        lifnds_pkg::REG_LEAK_FACTOR:     leak_factor     <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers with no reset
  always_ff @(posedge clk) begin
    cmp_syn  <= issue_syn;
    cmp_slot <= ring_head[issue_syn];
    if (accept && in_data.op == lifnds_pkg::OP_TICK) begin
      now <= in_data.time_step;
    end
    if (state == ST_LEAK) begin
      leak_prod <= LPROD_W'($signed({1'b0, leak_factor})) *
                   LPROD_W'(17'(rest_potential) - 17'(potential));
    end
    if (state == ST_DRIVE) begin
      drive_prod <= DPROD_W'($signed({1'b0, input_gain})) * DPROD_W'(sum);
    end
    if (state == ST_UPDATE && out_free) begin
      out_data.spike    <= fired;
      out_data.membrane <= fired ? reset_potential : v_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      potential <= lifnds_pkg::REST_POTENTIAL_RST;
      issue_cnt <= '0;
      cmp_act   <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < lifnds_pkg::N_SYNAPSES; s++) begin
        syn_weight[s] <= '0;
        syn_delay[s]  <= 8'd1;
        ring_head[s]  <= '0;
        ring_tail[s]  <= '0;
      end
    end else begin
      // drop the result once taken, unless the update refills it this cycle
      if (out_valid && out_ready && state != ST_UPDATE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.op)
              lifnds_pkg::OP_LOAD: begin
                if (idx_ok) begin
                  syn_weight[idx] <= in_data.weight;
                  syn_delay[idx]  <= in_data.delay;
                  ring_head[idx]  <= '0;
                  ring_tail[idx]  <= '0;
                end
              end
              lifnds_pkg::OP_SPIKE: begin
                // full ring: overwrite at the tail, leave the head alone
                if (idx_ok) begin
                  ring_tail[idx] <= slot_inc(ring_tail[idx]);
                end
              end
              lifnds_pkg::OP_TICK: begin
                state     <= ST_SCAN;
                issue_cnt <= '0;
                cmp_act   <= 1'b0;
                sum       <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cmp_act <= !issue_done;
          if (!issue_done) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (hit) begin
            sum                <= sum + SUM_W'(syn_weight[cmp_syn]);
            ring_head[cmp_syn] <= slot_inc(cmp_slot);
          end
          if (issue_done) begin
            state <= ST_LEAK;
          end
        end
        ST_LEAK: begin
          state <= ST_DRIVE;
        end
        ST_DRIVE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // hold until the output register is free
          if (out_free) begin
            potential <= fired ? reset_potential : v_sat;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // only one write-side ring command per cycle
  a_ring_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ring_cmd.wr, ring_cmd.clr, ring_cmd.kill}))
    else $error("ring: more than one command in a cycle");

  // a head is consumed only during the scan
  a_kill_in_scan: assert property (@(posedge clk) disable iff (rst)
    ring_cmd.kill |-> state == ST_SCAN)
    else $error("ring: slot consumed outside the scan");

  // the compare stage is live only within the scan
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_act |-> state == ST_SCAN)
    else $error("scan: compare stage live outside the scan");

  // a finished tick holds while the previous result is still waiting
  a_update_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && out_valid && !out_ready) |=> state == ST_UPDATE)
    else $error("update: result register overwritten");

  // a result appears only at the end of an update step
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_UPDATE)
    else $error("output: result without a tick");

endmodule
